### rtl/bfdh_pkg.sv
// Package for the double-hash Bloom filter: hash constants, register
// indexes, command codes and the sequencer state type. No dependencies.
`timescale 1ns / 1ps

package bfdh_pkg;

	localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
	localparam logic [63:0] FNV_PRIME = 64'h00000100000001b3;
	localparam logic [63:0] MUR_M     = 64'hc6a4a7935bd1e995;
	localparam int          MUR_R     = 47;
	localparam logic [63:0] MUR_SEED  = 64'hdeadbeefcafe1234;

	localparam int DEF_FILTER_BITS = 65536;
	localparam int DEF_MAX_HASHES  = 16;

	localparam logic [16:0] MOD_LEN_RST    = 17'd65536;
	localparam logic [4:0]  HASH_COUNT_RST = 5'd7;

	localparam logic [7:0] REG_MOD_LEN    = 8'd0;
	localparam logic [7:0] REG_HASH_COUNT = 8'd1;

	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_KLEN_W,
		S_FNV,
		S_FNV_W,
		S_MUR,
		S_MK1_W,
		S_MK2_W,
		S_MH_W,
		S_POST,
		S_FIN_W,
		S_MOD,
		S_WRITE,
		S_READ,
		S_CHECK,
		S_NEXT
	} state_t;

endpackage

### rtl/bfdh_mul.sv
// Shared 64x64 multiplier, low 64 bits of the product, built from one
// 32x32 multiplier. Standalone, no package use.
`timescale 1ns / 1ps

module bfdh_mul (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        busy,
	output logic        done,
	output logic [63:0] prod
);

	logic [63:0] a_q, b_q, pp_q, acc_q;
	logic [1:0]  ph_q;
	logic        busy_q;
	logic [31:0] op_x, op_y;

	// phase 0: lo*lo, 1: lo*hi, 2: hi*lo; each product is registered in pp_q
	always_comb begin
		case (ph_q)
			2'd0: begin
				op_x = a_q[31:0];
				op_y = b_q[31:0];
			end
			2'd1: begin
				op_x = a_q[31:0];
				op_y = b_q[63:32];
			end
			default: begin
				op_x = a_q[63:32];
				op_y = b_q[31:0];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			ph_q   <= 2'd0;
		end else if (start) begin
			busy_q <= 1'b1;
			ph_q   <= 2'd0;
		end else if (busy_q) begin
			ph_q <= ph_q + 2'd1;
			if (ph_q == 2'd3) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
		end
		pp_q <= op_x * op_y;
		if (ph_q == 2'd1) begin
			acc_q <= pp_q;
		end else if (ph_q == 2'd2) begin
			acc_q <= acc_q + {pp_q[31:0], 32'd0};
		end
	end

	assign busy = busy_q;
	assign done = busy_q && (ph_q == 2'd3);
	assign prod = acc_q + {pp_q[31:0], 32'd0};

endmodule

### rtl/bloom_filter_double_hash.sv
// Bloom filter with FNV-1a / MurmurHash64A double hashing, top level.
// Uses bfdh_pkg and the shared multiplier bfdh_mul.
//
//  channel  dir  handshake                       payload
//  s_axis   in   s_axis_tvalid / s_axis_tready   tdata{key_length,word_bytes,key_word},
//                                                tlast=last_word, tuser=command
//  m_axis   out  m_axis_tvalid / m_axis_tready   tdata[0]=may_contain, tuser=done_command
//  cfg      in   cfg_valid / cfg_ready           cfg_index, cfg_data
//
// Sequence: every multiply goes through the one 32x32 multiplier. A word runs
// one multiply per FNV byte, then three for a full Murmur block, one for a
// tail or none with no bytes; the first word of a key adds one for the seed.
// The last word adds one for finalization and, per position, the bit-serial
// modulo (64 steps), then a store write (add) or a registered store read (query).
// After reset a clearing pass zeroes every entry of the bit store, with no
// request accepted; configuration writes are taken at all times.
// A finished result waiting on m_axis holds off the next input request.
`timescale 1ns / 1ps

module bloom_filter_double_hash #(
	parameter int FILTER_BITS = bfdh_pkg::DEF_FILTER_BITS,
	parameter int MAX_HASHES  = bfdh_pkg::DEF_MAX_HASHES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // key_word[63:0], word_bytes[67:64], key_length[83:68]
	input  logic        s_axis_tlast,  // last_word
	input  logic        s_axis_tuser,  // command
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // may_contain[0]
	output logic        m_axis_tuser,  // done_command
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int ADDR_W = $clog2(FILTER_BITS);
	localparam int NB_W   = $clog2(FILTER_BITS + 1);
	localparam int K_W    = $clog2(MAX_HASHES + 1);

	bfdh_pkg::state_t state_q, state_d;

	// config
	logic [16:0] mod_len_q;
	logic [4:0]  hash_count_q;
	logic [31:0] nb_wide;
	logic [NB_W-1:0] nb_eff;
	logic [K_W-1:0]  k_eff;

	// per-word and per-key state
	logic [63:0] word_q, fnv_q, mur_q, x_q;
	logic [3:0]  nbytes_q, bcnt_q;
	logic        last_q, cmd_q, in_key_q, all_q;
	logic [NB_W-1:0] r_q;
	logic [5:0]  bit_q;
	logic [K_W-1:0] idx_q;

	// output register
	logic out_valid_q, out_may_q, out_cmd_q;

	// bit store
	logic mem [FILTER_BITS];
	logic [ADDR_W-1:0] clr_q;
	logic rd_q;
	logic mem_we, mem_wd;
	logic [ADDR_W-1:0] mem_wa;

	// shared multiplier
	logic        mul_start, mul_busy, mul_done;
	logic [63:0] mul_a, mul_b, mul_p, mul_px;

	// input unpack
	logic [63:0] in_word, in_mask;
	logic [3:0]  in_bytes, in_nb;
	logic [15:0] in_klen;
	logic        accept;

	// modulo step
	logic [NB_W:0] trial, trial_sub;
	logic          trial_ge;
	logic [7:0]    cur_byte;

	assign in_word  = s_axis_tdata[63:0];
	assign in_bytes = s_axis_tdata[67:64];
	assign in_klen  = s_axis_tdata[83:68];
	assign accept   = s_axis_tvalid && s_axis_tready;

	// a word that is not last always counts eight bytes
	assign in_nb = !s_axis_tlast ? 4'd8 : ((in_bytes > 4'd8) ? 4'd8 : in_bytes);

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			in_mask[b*8 +: 8] = (4'(b) < in_nb) ? 8'hff : 8'h00;
		end
	end

	always_comb begin
		nb_wide = {15'd0, mod_len_q};
		if (nb_wide < 32'd8) begin
			nb_wide = 32'd8;
		end
		if (nb_wide > 32'(FILTER_BITS)) begin
			nb_wide = 32'(FILTER_BITS);
		end
		nb_eff = nb_wide[NB_W-1:0];
		if ({3'd0, hash_count_q} > 8'(MAX_HASHES)) begin
			k_eff = K_W'(MAX_HASHES);
		end else begin
			k_eff = K_W'(hash_count_q);
		end
	end

	assign cur_byte = word_q[{bcnt_q[2:0], 3'b000} +: 8];
	assign mul_px   = mul_p ^ (mul_p >> bfdh_pkg::MUR_R);

	// one restoring-division step: bring in the next dividend bit
	assign trial     = {r_q, x_q[6'd63 - bit_q]};
	assign trial_ge  = trial >= {1'b0, nb_eff};
	assign trial_sub = trial - {1'b0, nb_eff};

	bfdh_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.busy   (mul_busy),
		.done   (mul_done),
		.prod   (mul_p)
	);

	// next state, multiplier launch, store write
	always_comb begin
		state_d   = state_q;
		mul_start = 1'b0;
		mul_a     = mul_p;
		mul_b     = bfdh_pkg::MUR_M;
		mem_we    = 1'b0;
		mem_wd    = 1'b0;
		mem_wa    = r_q[ADDR_W-1:0];
		case (state_q)
			bfdh_pkg::S_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				if (clr_q == ADDR_W'(FILTER_BITS - 1)) begin
					state_d = bfdh_pkg::S_IDLE;
				end
			end
			bfdh_pkg::S_IDLE: begin
				if (accept) begin
					if (!in_key_q) begin
						// murmur start value: seed ^ (len * m)
						mul_start = 1'b1;
						mul_a     = {48'd0, in_klen};
						state_d   = bfdh_pkg::S_KLEN_W;
					end else begin
						state_d = bfdh_pkg::S_FNV;
					end
				end
			end
			bfdh_pkg::S_KLEN_W: begin
				if (mul_done) begin
					state_d = bfdh_pkg::S_FNV;
				end
			end
			bfdh_pkg::S_FNV: begin
				if (bcnt_q < nbytes_q) begin
					mul_start = 1'b1;
					mul_a     = fnv_q ^ {56'd0, cur_byte};
					mul_b     = bfdh_pkg::FNV_PRIME;
					state_d   = bfdh_pkg::S_FNV_W;
				end else begin
					state_d = bfdh_pkg::S_MUR;
				end
			end
			bfdh_pkg::S_FNV_W: begin
				if (mul_done) begin
					state_d = bfdh_pkg::S_FNV;
				end
			end
			bfdh_pkg::S_MUR: begin
				if (nbytes_q == 4'd8) begin
					mul_start = 1'b1;
					mul_a     = word_q;
					state_d   = bfdh_pkg::S_MK1_W;
				end else if (nbytes_q != 4'd0) begin
					// tail bytes, already masked on accept
					mul_start = 1'b1;
					mul_a     = mur_q ^ word_q;
					state_d   = bfdh_pkg::S_MH_W;
				end else begin
					state_d = bfdh_pkg::S_POST;
				end
			end
			bfdh_pkg::S_MK1_W: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mul_px;
					state_d   = bfdh_pkg::S_MK2_W;
				end
			end
			bfdh_pkg::S_MK2_W: begin
				if (mul_done) begin
					mul_start = 1'b1;
					mul_a     = mur_q ^ mul_p;
					state_d   = bfdh_pkg::S_MH_W;
				end
			end
			bfdh_pkg::S_MH_W: begin
				if (mul_done) begin
					state_d = bfdh_pkg::S_POST;
				end
			end
			bfdh_pkg::S_POST: begin
				if (!last_q) begin
					state_d = bfdh_pkg::S_IDLE;
				end else begin
					mul_start = 1'b1;
					mul_a     = mur_q ^ (mur_q >> bfdh_pkg::MUR_R);
					state_d   = bfdh_pkg::S_FIN_W;
				end
			end
			bfdh_pkg::S_FIN_W: begin
				if (mul_done) begin
					state_d = (k_eff == '0) ? bfdh_pkg::S_NEXT : bfdh_pkg::S_MOD;
				end
			end
			bfdh_pkg::S_MOD: begin
				if (bit_q == 6'd63) begin
					state_d = (cmd_q == bfdh_pkg::CMD_ADD) ? bfdh_pkg::S_WRITE
					                                       : bfdh_pkg::S_READ;
				end
			end
			bfdh_pkg::S_WRITE: begin
				mem_we  = 1'b1;
				mem_wd  = 1'b1;
				state_d = bfdh_pkg::S_NEXT;
			end
			bfdh_pkg::S_READ: begin
				state_d = bfdh_pkg::S_CHECK;
			end
			bfdh_pkg::S_CHECK: begin
				state_d = bfdh_pkg::S_NEXT;
			end
			bfdh_pkg::S_NEXT: begin
				// zero positions reaches here straight from finalization
				if (k_eff == '0 || idx_q + K_W'(1) == k_eff) begin
					state_d = bfdh_pkg::S_IDLE;
				end else begin
					state_d = bfdh_pkg::S_MOD;
				end
			end
			default: begin
				state_d = bfdh_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bfdh_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mod_len_q    <= bfdh_pkg::MOD_LEN_RST;
			hash_count_q <= bfdh_pkg::HASH_COUNT_RST;
			clr_q        <= '0;
			in_key_q     <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == bfdh_pkg::REG_MOD_LEN) begin
					mod_len_q <= cfg_data[16:0];
				end else if (cfg_index == bfdh_pkg::REG_HASH_COUNT) begin
					hash_count_q <= cfg_data[4:0];
				end
			end
			if (state_q == bfdh_pkg::S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (accept) begin
				in_key_q <= 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == bfdh_pkg::S_NEXT && state_d == bfdh_pkg::S_IDLE) begin
				out_valid_q <= 1'b1;
				in_key_q    <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			word_q   <= in_word & in_mask;
			nbytes_q <= in_nb;
			last_q   <= s_axis_tlast;
			cmd_q    <= s_axis_tuser;
			bcnt_q   <= 4'd0;
			if (!in_key_q) begin
				fnv_q <= bfdh_pkg::FNV_BASIS;
			end
		end
		case (state_q)
			bfdh_pkg::S_KLEN_W: begin
				if (mul_done) begin
					mur_q <= bfdh_pkg::MUR_SEED ^ mul_p;
				end
			end
			bfdh_pkg::S_FNV_W: begin
				if (mul_done) begin
					fnv_q  <= mul_p;
					bcnt_q <= bcnt_q + 4'd1;
				end
			end
			bfdh_pkg::S_MH_W: begin
				if (mul_done) begin
					mur_q <= mul_p;
				end
			end
			bfdh_pkg::S_FIN_W: begin
				if (mul_done) begin
					mur_q <= mul_px;  // h2
					x_q   <= fnv_q;   // h1 + 0*h2
					idx_q <= '0;
					all_q <= 1'b1;
					r_q   <= '0;
					bit_q <= 6'd0;
				end
			end
			bfdh_pkg::S_MOD: begin
				r_q   <= trial_ge ? trial_sub[NB_W-1:0] : trial[NB_W-1:0];
				bit_q <= bit_q + 6'd1;
			end
			bfdh_pkg::S_CHECK: begin
				if (!rd_q) begin
					all_q <= 1'b0;
				end
			end
			bfdh_pkg::S_NEXT: begin
				idx_q <= idx_q + K_W'(1);
				x_q   <= x_q + mur_q;
				r_q   <= '0;
				bit_q <= 6'd0;
				if (state_d == bfdh_pkg::S_IDLE) begin
					out_cmd_q <= cmd_q;
					out_may_q <= (cmd_q == bfdh_pkg::CMD_ADD) ? 1'b1 : all_q;
					fnv_q     <= bfdh_pkg::FNV_BASIS;
					mur_q     <= bfdh_pkg::MUR_SEED;
				end
			end
			default: begin
			end
		endcase
	end

	// bit store, one write and one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (state_q == bfdh_pkg::S_READ) begin
			rd_q <= mem[r_q[ADDR_W-1:0]];
		end
	end

	assign s_axis_tready = (state_q == bfdh_pkg::S_IDLE) && !out_valid_q;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'd0, out_may_q};
	assign m_axis_tuser  = out_cmd_q;

	// remainder of the serial modulo stays below the modulus
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bfdh_pkg::S_MOD |-> r_q < nb_eff)
		else $error("modulo remainder out of range");

	// a result only appears once the key is closed
	a_key_closed: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> !in_key_q)
		else $error("result raised with key still open");

	// waiting on an FNV or finalization product means the multiplier is running
	a_mul_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == bfdh_pkg::S_FNV_W || state_q == bfdh_pkg::S_FIN_W) |-> mul_busy)
		else $error("multiplier idle during wait");

	// the modulo loop only leaves toward a store access
	a_mod_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == bfdh_pkg::S_MOD |=> (state_q == bfdh_pkg::S_MOD ||
			state_q == bfdh_pkg::S_WRITE || state_q == bfdh_pkg::S_READ))
		else $error("bad exit from modulo loop");

endmodule
